// ----- rtl/dses_pkg.sv -----
`timescale 1ns / 1ps

package dses_pkg;

   // Queue of released-later sync events
   localparam int QUEUE_DEPTH = 16;
   localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Command queue between front and back
   localparam int CMD_FIFO_DEPTH = 2;
   localparam int CF_IDX_W       = $clog2(CMD_FIFO_DEPTH);
   localparam int CF_CNT_W       = $clog2(CMD_FIFO_DEPTH + 1);

   // Input op codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds
   localparam logic EV_IMMEDIATE = 1'b0;
   localparam logic EV_DELAYED   = 1'b1;

   // Command kinds
   localparam logic [1:0] CMD_PCT  = 2'd0;
   localparam logic [1:0] CMD_SYNC = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // Byte classes
   localparam logic [7:0] PCT_MAX_BYTE = 8'd100;
   localparam logic [6:0] PCT_CLAMP    = 7'd99;
   localparam logic [7:0] SYNC_FIRST   = 8'd105;
   localparam logic [7:0] SYNC_LAST    = 8'd108;

   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2**23
   localparam logic [23:0] RECIP_100   = 24'd10737419;
   localparam int          RECIP_SHIFT = 30;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] arg;   // percent for CMD_PCT, eye value for CMD_SYNC
   } cmd_type;

   typedef struct packed {
      logic [1:0]  eye;
      logic [31:0] stamp;
   } pend_type;

endpackage

// ----- rtl/dses_front.sv -----
`timescale 1ns / 1ps

module dses_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output dses_pkg::cmd_type cmd
);

   dses_pkg::cmd_type cls;
   logic              keep;
   logic [7:0]        eye_diff;

   always_comb begin
      cls      = '0;
      keep     = 1'b0;
      eye_diff = req_tdata - dses_pkg::SYNC_FIRST;
      if (req_tuser == dses_pkg::OP_TICK) begin
         cls.kind = dses_pkg::CMD_TICK;
         keep     = 1'b1;
      end else if (req_tdata <= dses_pkg::PCT_MAX_BYTE) begin
         cls.kind = dses_pkg::CMD_PCT;
         cls.arg  = (req_tdata == dses_pkg::PCT_MAX_BYTE) ? dses_pkg::PCT_CLAMP
                                                          : req_tdata[6:0];
         keep     = 1'b1;
      end else if (req_tdata >= dses_pkg::SYNC_FIRST && req_tdata <= dses_pkg::SYNC_LAST) begin
         cls.kind = dses_pkg::CMD_SYNC;
         cls.arg  = {5'b0, eye_diff[1:0]};
         keep     = 1'b1;
      end
   end

   // small command queue; ignored bytes never enter it
   dses_pkg::cmd_type                   fifo_ff [dses_pkg::CMD_FIFO_DEPTH];
   logic [dses_pkg::CF_IDX_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dses_pkg::CF_IDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dses_pkg::CF_CNT_W-1:0]       count_ff, count_in;
   logic                                push, pop;

   assign req_tready = (count_ff != dses_pkg::CF_CNT_W'(dses_pkg::CMD_FIFO_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dses_pkg::CF_IDX_W'(dses_pkg::CMD_FIFO_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dses_pkg::CF_IDX_W'(dses_pkg::CMD_FIFO_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/dses_back.sv -----
`timescale 1ns / 1ps

module dses_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  dses_pkg::cmd_type cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCALE = 2'd1;
   localparam logic [1:0] ST_DUE   = 2'd2;

   localparam int Q_IDX_W_L = dses_pkg::Q_IDX_W;

   logic [1:0]                    state_ff, state_in;
   logic [31:0]                   tick_ff, tick_in;
   logic [31:0]                   last_sync_ff, last_sync_in;
   logic [15:0]                   period_ff, period_in;
   logic [6:0]                    percent_ff, percent_in;
   logic [Q_IDX_W_L-1:0]          head_ff, head_in;
   logic [Q_IDX_W_L-1:0]          tail_ff, tail_in;
   logic [dses_pkg::Q_CNT_W-1:0]  count_ff, count_in;
   logic [22:0]                   product_ff, product_in;
   logic [15:0]                   offset_ff, offset_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_kind_ff, out_kind_in;
   logic [1:0]                    out_eye_ff, out_eye_in;
   logic                          out_ovf_ff, out_ovf_in;

   dses_pkg::pend_type            pending_mem [dses_pkg::QUEUE_DEPTH];
   dses_pkg::pend_type            head_rd_ff;
   dses_pkg::pend_type            wr_entry;
   logic                          mem_we, mem_re;

   logic                          out_free;
   logic                          q_full;
   logic [46:0]                   scaled;
   logic [31:0]                   due;
   logic [15:0]                   tick_diff;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign q_full    = (count_ff == dses_pkg::Q_CNT_W'(dses_pkg::QUEUE_DEPTH));
   assign cmd_ready = (state_ff == ST_IDLE) && (cmd.kind != dses_pkg::CMD_SYNC || out_free);
   assign scaled    = product_ff * dses_pkg::RECIP_100;
   assign due       = head_rd_ff.stamp + {16'b0, offset_ff};
   assign tick_diff = 16'(tick_ff - last_sync_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {5'b0, out_ovf_ff, out_eye_ff};

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      last_sync_in = last_sync_ff;
      period_in    = period_ff;
      percent_in   = percent_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      product_in   = product_ff;
      offset_in    = offset_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_eye_in   = out_eye_ff;
      out_ovf_in   = out_ovf_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      wr_entry.eye   = cmd.arg[1:0];
      wr_entry.stamp = tick_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               case (cmd.kind)
                  dses_pkg::CMD_PCT: begin
                     percent_in = cmd.arg;
                  end
                  dses_pkg::CMD_SYNC: begin
                     if (cmd.arg[1:0] == 2'd0) begin
                        period_in    = tick_diff;
                        last_sync_in = tick_ff;
                     end
                     if (!q_full) begin
                        mem_we   = 1'b1;
                        tail_in  = (tail_ff == Q_IDX_W_L'(dses_pkg::QUEUE_DEPTH - 1))
                                   ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     out_valid_in = 1'b1;
                     out_kind_in  = dses_pkg::EV_IMMEDIATE;
                     out_eye_in   = cmd.arg[1:0];
                     out_ovf_in   = q_full;
                  end
                  dses_pkg::CMD_TICK: begin
                     tick_in    = tick_ff + 32'd1;
                     product_in = period_ff * percent_ff;
                     mem_re     = 1'b1;
                     state_in   = ST_SCALE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCALE: begin
            offset_in = scaled[dses_pkg::RECIP_SHIFT +: 16];
            state_in  = ST_DUE;
         end
         ST_DUE: begin
            if (count_ff == '0 || !(due < tick_ff)) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = dses_pkg::EV_DELAYED;
               out_eye_in   = head_rd_ff.eye;
               out_ovf_in   = 1'b0;
               head_in      = (head_ff == Q_IDX_W_L'(dses_pkg::QUEUE_DEPTH - 1))
                              ? '0 : head_ff + 1'b1;
               count_in     = count_ff - 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         last_sync_ff <= '0;
         period_ff    <= '0;
         percent_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         last_sync_ff <= last_sync_in;
         period_ff    <= period_in;
         percent_ff   <= percent_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      offset_ff   <= offset_in;
      out_kind_ff <= out_kind_in;
      out_eye_ff  <= out_eye_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // event queue storage: one write port at tail, registered read at head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pending_mem[tail_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         head_rd_ff <= pending_mem[head_ff];
      end
   end

endmodule

// ----- rtl/delayed_sync_event_scheduler.sv -----
`timescale 1ns / 1ps

// Delayed sync event scheduler.
// Input stream (req_): one beat per received serial byte or timer tick.
// Bytes 0..100 set the delay percent (100 is held as 99), bytes 105..108 are
// sync events, all other bytes are dropped in the front end.
// Output stream (rsp_): one beat per immediate sync report and one per
// delayed release of a queued sync event.
// With the back end idle, an immediate report passes through the command
// queue and the back end's output register before it shows on rsp_tvalid;
// a tick's release also passes through the SCALE and DUE states.
// Throughput: the two-entry command queue takes one beat a cycle while it is
// not full; the back end retires a byte command straight from idle and a
// tick in steps (multiply, divide by 100 through a reciprocal multiply, then
// the due compare on the stamp read from the event queue memory).
// Reset clears counters, period, percent and the event queue pointers; queue
// entries are not cleared; one is read on each tick but used only once written.
// A stalled rsp_tready holds the current result; the back end waits with its
// next result, and the input side keeps accepting until the command queue
// fills.
module delayed_sync_event_scheduler (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tuser,   // [0] op
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [1:0] eye_value, [2] queue_overflow, [7:3] zero
   output logic       rsp_tuser    // [0] event_kind
);

   logic              cmd_valid;
   logic              cmd_ready;
   dses_pkg::cmd_type cmd;

   dses_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   dses_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/dses_checker.sv -----
`timescale 1ns / 1ps

module dses_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_release_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dses_pkg::EV_DELAYED |-> !rsp_tdata[2])
      else $error("delayed release flagged overflow");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] == 5'd0)
      else $error("rsp_tdata pad bits set");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

endmodule

bind delayed_sync_event_scheduler dses_checker u_checker (.*);

// ----- bench/delayed_sync_event_scheduler_tb.sv -----
`timescale 1ns / 1ps

module delayed_sync_event_scheduler_tb;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int RANDOM_ITEMS     = 1050;
   localparam int CALM_ITEMS       = 300;
   localparam int IDLE_PCT         = 29;
   localparam int HOLD_CYCLES      = 250;
   localparam int DRAIN_CYCLES     = 20;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int LONG_TICKS       = 200;

   typedef struct packed {
      logic       kind;
      logic [1:0] eye;
      logic       overflow;
   } sync_report_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // [7:0] byte_value
   logic       req_tuser  = dses_pkg::OP_BYTE;   // [0] op
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;   // [1:0] eye_value, [2] queue_overflow, [7:3] zero
   logic       rsp_tuser;   // [0] event_kind

   delayed_sync_event_scheduler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // scheduler state as the bench sees it
   logic [31:0]        tick_cnt       = '0;
   logic [31:0]        last_eye0_tick = '0;
   logic [15:0]        eye_period_q   = '0;
   logic [6:0]         delay_pct      = '0;
   dses_pkg::pend_type pending_syncs[$];
   sync_report_type    expected_reports[$];

   int idle_pct     = 0;
   bit hold_trigger = 1'b0;
   int hold_left    = 0;
   int mismatches   = 0;
   int cycle_count  = 0;
   int n_immediate  = 0;
   int n_delayed    = 0;
   int n_overflow   = 0;
   int n_ticks      = 0;
   int n_ignored    = 0;
   int n_checked    = 0;

   function automatic void predict_beat(logic op, logic [7:0] b);
      logic [7:0]         code;
      logic [31:0]        span;
      logic [31:0]        offset;
      logic [31:0]        due;
      dses_pkg::pend_type entry;
      sync_report_type    rpt;
      if (op == dses_pkg::OP_BYTE) begin
         if (b <= dses_pkg::PCT_MAX_BYTE) begin
            delay_pct = (b > dses_pkg::PCT_CLAMP) ? dses_pkg::PCT_CLAMP : b[6:0];
         end else if (b >= dses_pkg::SYNC_FIRST && b <= dses_pkg::SYNC_LAST) begin
            code         = b - dses_pkg::SYNC_FIRST;
            rpt.kind     = dses_pkg::EV_IMMEDIATE;
            rpt.eye      = code[1:0];
            rpt.overflow = 1'b0;
            if (rpt.eye == 2'd0) begin
               span           = tick_cnt - last_eye0_tick;
               eye_period_q   = span[15:0];
               last_eye0_tick = tick_cnt;
            end
            if (pending_syncs.size() < dses_pkg::QUEUE_DEPTH) begin
               entry.eye   = rpt.eye;
               entry.stamp = tick_cnt;
               pending_syncs.push_back(entry);
            end else begin
               rpt.overflow = 1'b1;
               n_overflow++;
            end
            expected_reports.push_back(rpt);
            n_immediate++;
         end else begin
            n_ignored++;
         end
      end else begin
         tick_cnt = tick_cnt + 32'd1;
         n_ticks++;
         if (pending_syncs.size() > 0) begin
            entry  = pending_syncs[0];
            offset = (32'(eye_period_q) * 32'(delay_pct)) / 32'd100;
            due    = entry.stamp + {16'd0, offset[15:0]};
            if (due < tick_cnt) begin
               rpt.kind     = dses_pkg::EV_DELAYED;
               rpt.eye      = entry.eye;
               rpt.overflow = 1'b0;
               expected_reports.push_back(rpt);
               void'(pending_syncs.pop_front());
               n_delayed++;
            end
         end
      end
   endfunction

   function automatic void note_mismatch(string what, int want_v, int got_v);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES) begin
         $display("mismatch at cycle %0d, %s: expected %0d, got %0d",
                  cycle_count, what, want_v, got_v);
      end
   endfunction

   // called at a falling edge, returns at a falling edge; tvalid stays high
   task automatic send_beat(logic op, logic [7:0] b);
      int gap;
      if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         gap = $urandom_range(3, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_beat(op, b);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_beat(dses_pkg::OP_TICK, 8'($urandom_range(255, 0)));
   endtask

   task automatic send_sync(logic [1:0] eye);
      send_beat(dses_pkg::OP_BYTE, dses_pkg::SYNC_FIRST + 8'(eye));
   endtask

   // receiver side: random stalls, plus one long hold on request
   always @(negedge clock) begin
      if (hold_trigger) begin
         hold_trigger = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      sync_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            note_mismatch("beat with nothing pending", 0, int'(rsp_tdata));
         end else begin
            want = expected_reports.pop_front();
            n_checked++;
            if (rsp_tuser !== want.kind)
               note_mismatch("event_kind", want.kind, rsp_tuser);
            if (rsp_tdata[1:0] !== want.eye)
               note_mismatch("eye_value", want.eye, rsp_tdata[1:0]);
            if (rsp_tdata[2] !== want.overflow)
               note_mismatch("queue_overflow", want.overflow, rsp_tdata[2]);
            if (rsp_tdata[7:3] !== 5'd0)
               note_mismatch("tdata padding", 0, rsp_tdata[7:3]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_reports.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ignored bytes, ticks with extreme bytes, all sync codes, clamp to 99
   task automatic test_directed();
      idle_pct = IDLE_PCT;
      send_beat(dses_pkg::OP_BYTE, 8'd101);
      send_beat(dses_pkg::OP_BYTE, 8'd104);
      send_beat(dses_pkg::OP_BYTE, 8'd109);
      send_beat(dses_pkg::OP_BYTE, 8'd255);
      send_beat(dses_pkg::OP_TICK, 8'h00);
      send_beat(dses_pkg::OP_TICK, 8'hFF);
      for (int e = 0; e < 4; e++) send_sync(2'(e));
      send_beat(dses_pkg::OP_BYTE, dses_pkg::PCT_MAX_BYTE);
      repeat (4) send_tick();
      send_beat(dses_pkg::OP_BYTE, 8'd0);
      send_sync(2'd0);
      repeat (3) send_tick();
      send_beat(dses_pkg::OP_BYTE, 8'd1);
      send_sync(2'd3);
      repeat (2) send_tick();
   endtask

   // long receiver hold while syncs keep coming: fills the queue and overflows
   task automatic test_backpressure();
      send_beat(dses_pkg::OP_BYTE, 8'd0);
      req_tvalid <= 1'b0;
      @(posedge clock);
      hold_trigger = 1'b1;
      @(negedge clock);
      repeat (dses_pkg::QUEUE_DEPTH + 4) send_sync(2'($urandom_range(3, 0)));
      repeat (dses_pkg::QUEUE_DEPTH + 4) send_tick();
   endtask

   // eye-0 period over a long run of ticks
   task automatic test_long_period();
      idle_pct = 0;
      send_beat(dses_pkg::OP_BYTE, 8'd50);
      send_sync(2'd0);
      repeat (LONG_TICKS) send_tick();
      send_sync(2'd0);
      send_sync(2'd2);
      repeat (8) send_tick();
   endtask

   task automatic test_random(int n_items);
      int         done;
      int         sel;
      int         burst;
      logic [7:0] b;
      done = 0;
      while (done < n_items) begin
         idle_pct = (done < CALM_ITEMS) ? 0 : IDLE_PCT;
         sel      = $urandom_range(99, 0);
         if (sel < 2) begin
            // sync burst to push the queue toward full
            burst = $urandom_range(20, 6);
            repeat (burst) send_sync(2'($urandom_range(3, 0)));
            done += burst;
         end else if (sel < 50) begin
            send_tick();
            done++;
         end else if (sel < 73) begin
            send_sync(2'($urandom_range(3, 0)));
            done++;
         end else if (sel < 90) begin
            case ($urandom_range(7, 0))
               0: b = 8'd0;
               1: b = dses_pkg::PCT_MAX_BYTE;
               2: b = 8'(dses_pkg::PCT_CLAMP);
               default: b = 8'($urandom_range(100, 0));
            endcase
            send_beat(dses_pkg::OP_BYTE, b);
            done++;
         end else begin
            // junk bytes, not counted
            if ($urandom_range(1, 0) == 0) b = 8'($urandom_range(104, 101));
            else b = 8'($urandom_range(255, 109));
            send_beat(dses_pkg::OP_BYTE, b);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_long_period();
      test_random(RANDOM_ITEMS);
      req_tvalid <= 1'b0;
      idle_pct = IDLE_PCT;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d ticks, %0d ignored bytes, %0d immediate reports",
               n_ticks, n_ignored, n_immediate);
      $display("(%0d with queue full), %0d delayed releases; %0d beats checked, %0d bad",
               n_overflow, n_delayed, n_checked, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
